/* rtl/isotp_rx_pkg.sv */
package isotp_rx_pkg;

    localparam int BUFFER_BYTES = 64;
    localparam int DID_SLOTS    = 4;
    localparam int FRAME_BYTES  = 8;

    localparam int ID_W     = 29;
    localparam int LEN_W    = 4;
    localparam int TOTAL_W  = 12;
    localparam int ADDR_W   = $clog2(BUFFER_BYTES);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int CMP_W    = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;
    localparam int POS_W    = $clog2(FRAME_BYTES) + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 29;

    // protocol control information frame types
    localparam logic [3:0] PCI_SINGLE      = 4'h0;
    localparam logic [3:0] PCI_FIRST       = 4'h1;
    localparam logic [3:0] PCI_CONSECUTIVE = 4'h2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_CAN_ID     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POSITIVE_SERVICE_ID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DID_SLOT_0          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DID_SLOT_ENABLE     = 3'd6;

    // frame decode outcome
    localparam logic [2:0] DEC_NONE     = 3'd0;
    localparam logic [2:0] DEC_SINGLE   = 3'd1;
    localparam logic [2:0] DEC_FF_LEN   = 3'd2;
    localparam logic [2:0] DEC_FF_START = 3'd3;
    localparam logic [2:0] DEC_CF_BAD   = 3'd4;
    localparam logic [2:0] DEC_CF_OK    = 3'd5;

    typedef struct packed {
        logic load_frame;
        logic apply_decode;
        logic append_step;
        logic finish;
        logic emit_sf;
        logic emit_buf;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] dec;
        logic       append_done;
        logic       complete;
        logic       count_zero;
        logic       out_free;
        logic       sf_last;
        logic       buf_last;
    } dp_status_t;

endpackage

/* rtl/isotp_rx_ram.sv */
module isotp_rx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/isotp_rx_ctrl.sv */
module isotp_rx_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  isotp_rx_pkg::dp_status_t status,
    output isotp_rx_pkg::dp_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_DECODE    = 3'd1;
    localparam logic [2:0] ST_APPEND_FF = 3'd2;
    localparam logic [2:0] ST_APPEND_CF = 3'd3;
    localparam logic [2:0] ST_CHECK     = 3'd4;
    localparam logic [2:0] ST_SF_OUT    = 3'd5;
    localparam logic [2:0] ST_BUF_RD    = 3'd6;
    localparam logic [2:0] ST_BUF_LOAD  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_frame = 1'b1;
                    state_next     = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.apply_decode = 1'b1;
                unique case (status.dec)
                    isotp_rx_pkg::DEC_SINGLE:   state_next = ST_SF_OUT;
                    isotp_rx_pkg::DEC_FF_START: state_next = ST_APPEND_FF;
                    isotp_rx_pkg::DEC_CF_OK:    state_next = ST_APPEND_CF;
                    default:                    state_next = ST_IDLE;
                endcase
            end
            ST_APPEND_FF: begin
                if (status.append_done) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.append_step = 1'b1;
                end
            end
            ST_APPEND_CF: begin
                if (status.append_done) begin
                    state_next = ST_CHECK;
                end else begin
                    cmd.append_step = 1'b1;
                end
            end
            ST_CHECK: begin
                if (status.complete) begin
                    cmd.finish = 1'b1;
                    state_next = status.count_zero ? ST_IDLE : ST_BUF_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SF_OUT: begin
                if (status.out_free) begin
                    cmd.emit_sf = 1'b1;
                    if (status.sf_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_BUF_RD: begin
                state_next = ST_BUF_LOAD;
            end
            ST_BUF_LOAD: begin
                if (status.out_free) begin
                    cmd.emit_buf = 1'b1;
                    state_next   = status.buf_last ? ST_IDLE : ST_BUF_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/isotp_rx_dp.sv */
module isotp_rx_dp (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  isotp_rx_pkg::dp_cmd_t                            cmd,
    output isotp_rx_pkg::dp_status_t                         status,
    input  logic                                             cfg_valid,
    input  logic [isotp_rx_pkg::CFG_IDX_W-1:0]               cfg_index,
    input  logic [isotp_rx_pkg::CFG_DATA_W-1:0]              cfg_data,
    input  logic [isotp_rx_pkg::ID_W-1:0]                    frame_id,
    input  logic [isotp_rx_pkg::LEN_W-1:0]                   frame_len,
    input  logic [isotp_rx_pkg::FRAME_BYTES-1:0][7:0]        frame_bytes,
    input  logic                                             m_ready,
    output logic                                             m_valid,
    output logic [7:0]                                       m_message_byte,
    output logic [isotp_rx_pkg::ID_W-1:0]                    m_source_id,
    output logic                                             m_last_byte
);

    localparam int ADDR_W = isotp_rx_pkg::ADDR_W;
    localparam int CNT_W  = isotp_rx_pkg::CNT_W;
    localparam int POS_W  = isotp_rx_pkg::POS_W;
    localparam int CMP_W  = isotp_rx_pkg::CMP_W;
    localparam int SLOTS  = isotp_rx_pkg::DID_SLOTS;
    localparam int NBYTES = isotp_rx_pkg::FRAME_BYTES;

    // configuration
    logic [isotp_rx_pkg::ID_W-1:0] resp_id_reg;
    logic [7:0]                    psid_reg;
    logic [15:0]                   did_reg [SLOTS];
    logic [SLOTS-1:0]              did_en_reg;

    // captured frame
    logic [isotp_rx_pkg::ID_W-1:0]  id_reg;
    logic [isotp_rx_pkg::LEN_W-1:0] len_reg;
    logic [NBYTES-1:0][7:0]         byte_reg;

    // reassembly state
    logic                                collecting_reg, collecting_next;
    logic [3:0]                          seq_reg, seq_next;
    logic [isotp_rx_pkg::TOTAL_W-1:0]    total_reg, total_next;
    logic [CNT_W-1:0]                    count_reg, count_next;
    logic [POS_W-1:0]                    pos_reg, pos_next;
    logic [CNT_W-1:0]                    emit_n_reg;
    logic [CNT_W-1:0]                    emit_idx_reg;

    // output word
    logic                          m_valid_reg;
    logic [7:0]                    m_byte_reg;
    logic [isotp_rx_pkg::ID_W-1:0] m_id_reg;
    logic                          m_last_reg;

    logic [3:0]       pci_type;
    logic [3:0]       nib;
    logic             did_hit;
    logic             ff_match;
    logic [2:0]       dec;
    logic [7:0]       pos_byte;
    logic [7:0]       rd_data;
    logic             ram_we;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resp_id_reg <= isotp_rx_pkg::ID_W'(32'h7DC);
            psid_reg    <= 8'h62;
            for (int s = 0; s < SLOTS; s++) begin
                did_reg[s] <= (s == 0) ? 16'h0101 : 16'h0000;
            end
            did_en_reg  <= SLOTS'(1);
        end else if (cfg_valid) begin
            if (cfg_index == isotp_rx_pkg::REG_RESPONSE_CAN_ID) begin
                resp_id_reg <= cfg_data[isotp_rx_pkg::ID_W-1:0];
            end
            if (cfg_index == isotp_rx_pkg::REG_POSITIVE_SERVICE_ID) begin
                psid_reg <= cfg_data[7:0];
            end
            for (int s = 0; s < SLOTS; s++) begin
                if (cfg_index == isotp_rx_pkg::REG_DID_SLOT_0 +
                                 isotp_rx_pkg::CFG_IDX_W'(s)) begin
                    did_reg[s] <= cfg_data[15:0];
                end
            end
            if (cfg_index == isotp_rx_pkg::REG_DID_SLOT_ENABLE) begin
                did_en_reg <= cfg_data[SLOTS-1:0];
            end
        end
    end

    // decode
    assign pci_type = byte_reg[0][7:4];
    assign nib      = byte_reg[0][3:0];

    always_comb begin
        did_hit = 1'b0;
        for (int s = 0; s < SLOTS; s++) begin
            if (did_en_reg[s] && did_reg[s] == {byte_reg[3], byte_reg[4]}) begin
                did_hit = 1'b1;
            end
        end
    end

    assign ff_match = (byte_reg[2] == psid_reg) && (len_reg >= 4'd5) &&
                      (id_reg == resp_id_reg) && did_hit;

    always_comb begin
        dec = isotp_rx_pkg::DEC_NONE;
        if (len_reg != '0) begin
            unique case (pci_type)
                isotp_rx_pkg::PCI_SINGLE: begin
                    if (nib != 4'd0 && ({1'b0, nib} + 5'd1) <= {1'b0, len_reg}) begin
                        dec = isotp_rx_pkg::DEC_SINGLE;
                    end
                end
                isotp_rx_pkg::PCI_FIRST: begin
                    if (len_reg >= 4'd3) begin
                        dec = ff_match ? isotp_rx_pkg::DEC_FF_START
                                       : isotp_rx_pkg::DEC_FF_LEN;
                    end
                end
                isotp_rx_pkg::PCI_CONSECUTIVE: begin
                    if (collecting_reg) begin
                        dec = (nib == seq_reg) ? isotp_rx_pkg::DEC_CF_OK
                                               : isotp_rx_pkg::DEC_CF_BAD;
                    end
                end
                default: dec = isotp_rx_pkg::DEC_NONE;
            endcase
        end
    end

    assign pos_byte = byte_reg[pos_reg[POS_W-2:0]];

    assign status.dec         = dec;
    assign status.append_done = ({1'b0, pos_reg} >= (POS_W+1)'(len_reg)) ||
                                (count_reg == CNT_W'(isotp_rx_pkg::BUFFER_BYTES));
    assign status.complete    = CMP_W'(count_reg) >= CMP_W'(total_reg);
    assign status.count_zero  = (count_reg == '0);
    assign status.out_free    = !m_valid_reg || m_ready;
    assign status.sf_last     = (pos_reg == POS_W'(nib));
    assign status.buf_last    = ((emit_idx_reg + CNT_W'(1)) == emit_n_reg);

    assign ram_we = cmd.append_step;

    always_comb begin
        collecting_next = collecting_reg;
        seq_next        = seq_reg;
        total_next      = total_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        if (cmd.apply_decode) begin
            unique case (dec)
                isotp_rx_pkg::DEC_SINGLE: begin
                    pos_next = POS_W'(1);
                end
                isotp_rx_pkg::DEC_FF_LEN: begin
                    total_next = {nib, byte_reg[1]};
                end
                isotp_rx_pkg::DEC_FF_START: begin
                    total_next      = {nib, byte_reg[1]};
                    collecting_next = 1'b1;
                    seq_next        = 4'd1;
                    count_next      = '0;
                    pos_next        = POS_W'(2);
                end
                isotp_rx_pkg::DEC_CF_BAD: begin
                    collecting_next = 1'b0;
                    count_next      = '0;
                end
                isotp_rx_pkg::DEC_CF_OK: begin
                    pos_next = POS_W'(1);
                    seq_next = seq_reg + 4'd1;
                end
                default: ;
            endcase
        end
        if (cmd.append_step) begin
            pos_next   = pos_reg + POS_W'(1);
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.finish) begin
            collecting_next = 1'b0;
            count_next      = '0;
        end
        if (cmd.emit_sf) begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg <= 1'b0;
            seq_reg        <= 4'd1;
            total_reg      <= '0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            collecting_reg <= collecting_next;
            seq_reg        <= seq_next;
            total_reg      <= total_next;
            count_reg      <= count_next;
            if (cmd.emit_sf || cmd.emit_buf) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        if (cmd.load_frame) begin
            id_reg   <= frame_id;
            len_reg  <= (frame_len > 4'd8) ? 4'd8 : frame_len;
            byte_reg <= frame_bytes;
        end
        if (cmd.finish) begin
            emit_n_reg   <= count_reg;
            emit_idx_reg <= '0;
        end else if (cmd.emit_buf) begin
            emit_idx_reg <= emit_idx_reg + CNT_W'(1);
        end
        if (cmd.emit_sf) begin
            m_byte_reg <= pos_byte;
            m_id_reg   <= id_reg;
            m_last_reg <= status.sf_last;
        end else if (cmd.emit_buf) begin
            m_byte_reg <= rd_data;
            m_id_reg   <= id_reg;
            m_last_reg <= status.buf_last;
        end
    end

    isotp_rx_ram #(
        .WIDTH (8),
        .DEPTH (isotp_rx_pkg::BUFFER_BYTES)
    ) u_buf (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (pos_byte),
        .rd_addr (emit_idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign m_valid        = m_valid_reg;
    assign m_message_byte = m_byte_reg;
    assign m_source_id    = m_id_reg;
    assign m_last_byte    = m_last_reg;

endmodule

/* rtl/isotp_receive_reassembler_core.sv */
// ISO-TP receive reassembler. One CAN frame is taken per word on the s_ channel;
// message bytes leave one per word on the m_ channel with the identifier of the
// frame that completed them and a flag on the final byte. Single frames are
// passed through, first frames matching the response identifier, service byte
// and an enabled DID slot open a collection, and consecutive frames with the
// right sequence number are appended until the announced length is reached.
// Frames are handled one at a time: each is captured and decoded, then a
// first or consecutive frame stores one byte per cycle through the single write
// port of the collection RAM. A single frame's bytes go straight to the output
// register; a completed message is read back through the registered read of the
// RAM. The output register lets the next frame be taken while the last byte
// waits. Configuration writes are taken every cycle and belong to idle time.
module isotp_receive_reassembler_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [isotp_rx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [isotp_rx_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [isotp_rx_pkg::ID_W-1:0]        s_frame_id,
    input  logic [isotp_rx_pkg::LEN_W-1:0]       s_frame_len,
    input  logic [7:0]                           s_byte_0,
    input  logic [7:0]                           s_byte_1,
    input  logic [7:0]                           s_byte_2,
    input  logic [7:0]                           s_byte_3,
    input  logic [7:0]                           s_byte_4,
    input  logic [7:0]                           s_byte_5,
    input  logic [7:0]                           s_byte_6,
    input  logic [7:0]                           s_byte_7,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [7:0]                           m_message_byte,
    output logic [isotp_rx_pkg::ID_W-1:0]        m_source_id,
    output logic                                 m_last_byte
);

    isotp_rx_pkg::dp_cmd_t    cmd;
    isotp_rx_pkg::dp_status_t status;
    logic [isotp_rx_pkg::FRAME_BYTES-1:0][7:0] frame_bytes;

    assign cfg_ready   = 1'b1;
    assign frame_bytes = {s_byte_7, s_byte_6, s_byte_5, s_byte_4,
                          s_byte_3, s_byte_2, s_byte_1, s_byte_0};

    isotp_rx_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    isotp_rx_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .frame_id       (s_frame_id),
        .frame_len      (s_frame_len),
        .frame_bytes    (frame_bytes),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_message_byte (m_message_byte),
        .m_source_id    (m_source_id),
        .m_last_byte    (m_last_byte)
    );

endmodule

/* dv/tb_top.sv */
module tb_top;

    localparam int ID_W         = isotp_rx_pkg::ID_W;
    localparam int LEN_W        = isotp_rx_pkg::LEN_W;
    localparam int TOTAL_W      = isotp_rx_pkg::TOTAL_W;
    localparam int CFG_IDX_W    = isotp_rx_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = isotp_rx_pkg::CFG_DATA_W;
    localparam int DID_SLOTS    = isotp_rx_pkg::DID_SLOTS;
    localparam int BUFFER_BYTES = isotp_rx_pkg::BUFFER_BYTES;
    localparam int FRAME_BYTES  = isotp_rx_pkg::FRAME_BYTES;

    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [LEN_W-1:0] len;
        logic [7:0][7:0]  data;
    } can_frame_t;

    typedef struct packed {
        logic [7:0]      msg_byte;
        logic [ID_W-1:0] src_id;
        logic            last;
    } msg_word_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [ID_W-1:0]       s_frame_id = '0;
    logic [LEN_W-1:0]      s_frame_len = '0;
    logic [7:0]            s_byte_0 = '0;
    logic [7:0]            s_byte_1 = '0;
    logic [7:0]            s_byte_2 = '0;
    logic [7:0]            s_byte_3 = '0;
    logic [7:0]            s_byte_4 = '0;
    logic [7:0]            s_byte_5 = '0;
    logic [7:0]            s_byte_6 = '0;
    logic [7:0]            s_byte_7 = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [7:0]            m_message_byte;
    logic [ID_W-1:0]       m_source_id;
    logic                  m_last_byte;

    // receive-side configuration as the block should hold it
    logic [ID_W-1:0]       rx_can_id = 29'h7DC;
    logic [7:0]            service_id = 8'h62;
    logic [15:0]           did_slot_cfg [DID_SLOTS] = '{16'h0101, 16'h0000, 16'h0000, 16'h0000};
    logic [DID_SLOTS-1:0]  did_enable = 4'b0001;

    // reassembly state
    logic [7:0]            rx_buf [BUFFER_BYTES];
    logic [3:0]            rx_seq = 4'd1;
    bit                    rx_active = 1'b0;
    logic [TOTAL_W-1:0]    rx_total = '0;
    int                    rx_count = 0;

    can_frame_t            can_frames_pending [$];
    msg_word_t             msg_bytes_due [$];
    can_frame_t            on_bus = '0;
    can_frame_t            next_frame;
    msg_word_t             due_word;

    int                    send_gap = 0;
    int                    recv_gap = 0;
    int                    hold_count = 0;
    bit                    hold_req = 1'b0;
    bit                    hold_done = 1'b0;
    bit                    s_idle_on = 1'b1;
    bit                    m_idle_on = 1'b1;
    int                    quiet_cycles = 0;
    int                    failures = 0;
    int                    planned_frames = 0;
    int                    frames_taken = 0;
    int                    bytes_seen = 0;
    int                    msgs_seen = 0;
    int                    settings_used = 1;

    isotp_receive_reassembler_core i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_frame_id     (s_frame_id),
        .s_frame_len    (s_frame_len),
        .s_byte_0       (s_byte_0),
        .s_byte_1       (s_byte_1),
        .s_byte_2       (s_byte_2),
        .s_byte_3       (s_byte_3),
        .s_byte_4       (s_byte_4),
        .s_byte_5       (s_byte_5),
        .s_byte_6       (s_byte_6),
        .s_byte_7       (s_byte_7),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_message_byte (m_message_byte),
        .m_source_id    (m_source_id),
        .m_last_byte    (m_last_byte)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void store_bytes(can_frame_t f, int from, int n);
        for (int i = from; i < n && rx_count < BUFFER_BYTES; i++) begin
            rx_buf[rx_count] = f.data[i];
            rx_count++;
        end
    endfunction

    function automatic void absorb_frame(can_frame_t f);
        int         n;
        logic [3:0] nib;
        logic [15:0] did;
        bit         hit;
        msg_word_t  w;
        n = (f.len > FRAME_BYTES) ? FRAME_BYTES : int'(f.len);
        nib = f.data[0][3:0];
        hit = 1'b0;
        if (n != 0) begin
            case (f.data[0][7:4])
                isotp_rx_pkg::PCI_SINGLE: begin
                    if (int'(nib) != 0 && int'(nib) + 1 <= n) begin
                        for (int k = 0; k < int'(nib); k++) begin
                            w.msg_byte = f.data[1 + k];
                            w.src_id = f.id;
                            w.last = (k + 1 == int'(nib));
                            msg_bytes_due.push_back(w);
                        end
                    end
                end
                isotp_rx_pkg::PCI_FIRST: begin
                    if (n >= 3) begin
                        rx_total = {nib, f.data[1]};
                        did = {f.data[3], f.data[4]};
                        for (int s = 0; s < DID_SLOTS; s++)
                            if (did_enable[s] && did_slot_cfg[s] == did) hit = 1'b1;
                        if (f.data[2] == service_id && n >= 5 && f.id == rx_can_id && hit) begin
                            rx_active = 1'b1;
                            rx_seq = 4'd1;
                            rx_count = 0;
                            store_bytes(f, 2, n);
                        end
                    end
                end
                isotp_rx_pkg::PCI_CONSECUTIVE: begin
                    if (rx_active) begin
                        if (nib != rx_seq) begin
                            rx_active = 1'b0;
                            rx_count = 0;
                        end else begin
                            store_bytes(f, 1, n);
                            rx_seq = rx_seq + 4'd1;
                            if (rx_count >= int'(rx_total)) begin
                                for (int k = 0; k < rx_count; k++) begin
                                    w.msg_byte = rx_buf[k];
                                    w.src_id = f.id;
                                    w.last = (k + 1 == rx_count);
                                    msg_bytes_due.push_back(w);
                                end
                                rx_active = 1'b0;
                                rx_count = 0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
            failures++;
        end
    endfunction

    function automatic void push_frame(can_frame_t f);
        can_frames_pending.push_back(f);
        planned_frames++;
    endfunction

    function automatic logic [15:0] pick_did();
        int on_slots [$];
        for (int s = 0; s < DID_SLOTS; s++)
            if (did_enable[s]) on_slots.push_back(s);
        if (on_slots.size() == 0) return 16'($urandom);
        return did_slot_cfg[on_slots[$urandom_range(0, on_slots.size() - 1)]];
    endfunction

    task automatic queue_direct(logic [ID_W-1:0] id, logic [LEN_W-1:0] len, logic [63:0] data);
        can_frame_t f;
        f.id = id;
        f.len = len;
        f.data = data;
        push_frame(f);
    endtask

    // frames that are not part of a well-formed message; not counted
    task automatic queue_noise();
        can_frame_t f;
        f.id = ID_W'($urandom);
        f.len = LEN_W'($urandom_range(0, 15));
        f.data = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: f.data[0][7:4] = 4'($urandom_range(3, 15));
            1: f.data[0][7:4] = isotp_rx_pkg::PCI_CONSECUTIVE;
            2: f.data[0][7:4] = isotp_rx_pkg::PCI_FIRST;
            default: ;
        endcase
        can_frames_pending.push_back(f);
    endtask

    task automatic queue_message();
        can_frame_t f;
        int         total;
        int         have;
        int         cf_n;
        int         err_at;
        int         spoil;
        int         r;
        int         k;
        bit         short_cfs;
        bit         broke;
        logic [3:0] seq;
        logic [3:0] bad_seq;
        logic [15:0] did;
        r = $urandom_range(0, 99);
        if (r < 55) total = $urandom_range(7, 40);
        else if (r < 72) total = $urandom_range(41, 64);
        else if (r < 82) total = $urandom_range(0, 6);
        else if (r < 92) total = $urandom_range(65, 255);
        else total = $urandom_range(256, 4095);
        short_cfs = ($urandom_range(0, 7) == 0);
        spoil = $urandom_range(0, 99);
        did = pick_did();
        f.id = rx_can_id;
        f.len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(9, 15))
                                            : LEN_W'($urandom_range(5, 8));
        f.data = {$urandom, $urandom};
        f.data[0] = {isotp_rx_pkg::PCI_FIRST, total[11:8]};
        f.data[1] = total[7:0];
        f.data[2] = service_id;
        f.data[3] = did[15:8];
        f.data[4] = did[7:0];
        if (spoil < 6) f.id ^= 29'd1 << $urandom_range(0, 28);
        else if (spoil < 11) f.data[2] ^= 8'd1 << $urandom_range(0, 7);
        else if (spoil < 16) f.data[3 + $urandom_range(0, 1)] ^= 8'd1 << $urandom_range(0, 7);
        else if (spoil < 19) f.len = LEN_W'($urandom_range(3, 4));
        push_frame(f);
        have = ((f.len > FRAME_BYTES) ? FRAME_BYTES : int'(f.len)) - 2;
        seq = 4'd1;
        err_at = (spoil >= 19 && spoil < 27) ? int'($urandom_range(0, 5)) : -1;
        cf_n = $urandom_range(1, 12);
        k = 0;
        broke = 1'b0;
        do begin
            if ($urandom_range(0, 24) == 0) queue_noise();
            f.id = ($urandom_range(0, 9) < 7) ? rx_can_id : 29'($urandom);
            r = $urandom_range(0, 99);
            if (short_cfs || r < 15) f.len = LEN_W'($urandom_range(2, 3));
            else if (r < 90) f.len = LEN_W'($urandom_range(4, 8));
            else f.len = LEN_W'($urandom_range(9, 15));
            f.data = {$urandom, $urandom};
            bad_seq = seq + 4'($urandom_range(1, 15));
            f.data[0] = {isotp_rx_pkg::PCI_CONSECUTIVE, (k == err_at) ? bad_seq : seq};
            broke = (k == err_at);
            push_frame(f);
            have += ((f.len > FRAME_BYTES) ? FRAME_BYTES : int'(f.len)) - 1;
            seq = seq + 4'd1;
            k++;
        end while (!broke && ((total > BUFFER_BYTES) ? (k < cf_n) : (have < total)));
    endtask

    task automatic random_traffic(int budget);
        can_frame_t f;
        int         stop_at;
        int         r;
        logic [3:0] nib;
        stop_at = planned_frames + budget;
        while (planned_frames < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                queue_message();
            end else if (r < 82) begin
                nib = 4'($urandom_range(1, 7));
                f.id = ID_W'($urandom);
                f.len = LEN_W'($urandom_range(int'(nib) + 1, 15));
                f.data = {$urandom, $urandom};
                f.data[0] = {isotp_rx_pkg::PCI_SINGLE, nib};
                push_frame(f);
            end else begin
                queue_noise();
            end
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            isotp_rx_pkg::REG_RESPONSE_CAN_ID: rx_can_id = val[ID_W-1:0];
            isotp_rx_pkg::REG_POSITIVE_SERVICE_ID: service_id = val[7:0];
            isotp_rx_pkg::REG_DID_SLOT_ENABLE: did_enable = val[DID_SLOTS-1:0];
            default: did_slot_cfg[2'(idx - isotp_rx_pkg::REG_DID_SLOT_0)] = val[15:0];
        endcase
    endtask

    task automatic load_settings(logic [ID_W-1:0] can_id, logic [7:0] svc, logic [15:0] d0,
                                 logic [15:0] d1, logic [15:0] d2, logic [15:0] d3,
                                 logic [3:0] en);
        write_reg(isotp_rx_pkg::REG_RESPONSE_CAN_ID, can_id);
        write_reg(isotp_rx_pkg::REG_POSITIVE_SERVICE_ID, CFG_DATA_W'(svc));
        write_reg(isotp_rx_pkg::REG_DID_SLOT_0, CFG_DATA_W'(d0));
        write_reg(isotp_rx_pkg::REG_DID_SLOT_0 + 3'd1, CFG_DATA_W'(d1));
        write_reg(isotp_rx_pkg::REG_DID_SLOT_0 + 3'd2, CFG_DATA_W'(d2));
        write_reg(isotp_rx_pkg::REG_DID_SLOT_0 + 3'd3, CFG_DATA_W'(d3));
        write_reg(isotp_rx_pkg::REG_DID_SLOT_ENABLE, CFG_DATA_W'(en));
        cfg_valid <= 1'b0;
        settings_used++;
        @(negedge aclk);
    endtask

    task automatic wait_quiet();
        while (can_frames_pending.size() != 0 || s_valid || msg_bytes_due.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // frame sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_frame(on_bus);
                frames_taken++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0 || can_frames_pending.size() == 0) begin
                    s_valid <= 1'b0;
                    if (send_gap != 0) send_gap <= send_gap - 1;
                end else begin
                    next_frame = can_frames_pending.pop_front();
                    on_bus <= next_frame;
                    s_frame_id <= next_frame.id;
                    s_frame_len <= next_frame.len;
                    s_byte_0 <= next_frame.data[0];
                    s_byte_1 <= next_frame.data[1];
                    s_byte_2 <= next_frame.data[2];
                    s_byte_3 <= next_frame.data[3];
                    s_byte_4 <= next_frame.data[4];
                    s_byte_5 <= next_frame.data[5];
                    s_byte_6 <= next_frame.data[6];
                    s_byte_7 <= next_frame.data[7];
                    s_valid <= 1'b1;
                    send_gap <= s_idle_on ? pick_gap() : 0;
                end
            end
        end
    end

    // message byte receiver and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap <= 0;
            hold_count <= 0;
            hold_done <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                bytes_seen++;
                if (m_last_byte) msgs_seen++;
                if (msg_bytes_due.size() == 0) begin
                    $display("%0t: unexpected word, byte %h id %h last %b", $time,
                             m_message_byte, m_source_id, m_last_byte);
                    failures++;
                end else begin
                    due_word = msg_bytes_due.pop_front();
                    check_field("message_byte", 32'(due_word.msg_byte), 32'(m_message_byte));
                    check_field("source_id", 32'(due_word.src_id), 32'(m_source_id));
                    check_field("last_byte", 32'(due_word.last), 32'(m_last_byte));
                end
            end
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                hold_count <= hold_count + 1;
                if (hold_count == HOLD_CYCLES) hold_done <= 1'b1;
            end else if (recv_gap != 0) begin
                m_ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                m_ready <= 1'b1;
                recv_gap <= m_idle_on ? pick_gap() : 0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [63:0] blk;
        logic [3:0]  seq4;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, with the settings out of reset
        queue_direct(29'h1FFFFFFF, 4'd8, 64'hFFFF_FFFF_FFFF_FF07);
        queue_direct(29'h0, 4'd2, 64'h0000_0000_0000_0001);
        queue_direct(29'h7DC, 4'd0, 64'h0000_0000_0000_0103);
        queue_direct(29'h7DC, 4'hF, 64'h8877_6655_4433_2207);
        queue_direct(29'h7DC, 4'd8, 64'h1111_1111_1111_1100);
        queue_direct(29'h7DC, 4'd5, 64'h0000_0044_3322_1105);
        queue_direct(29'h7DC, 4'd2, 64'h0000_0000_0000_1410);
        queue_direct(29'h7DC, 4'd8, 64'h0000_0000_0000_0021);
        queue_direct(29'h7DC, 4'd8, 64'h5555_5555_5555_5530);
        queue_direct(29'h7DC, 4'd8, 64'hAAAA_AAAA_AAAA_AAF5);
        queue_direct(29'h7DC, 4'd8, 64'hCCBB_AA01_0162_1410);
        queue_direct(29'h123, 4'd3, 64'h0000_0000_00DE_AD02);
        queue_direct(29'h7DC, 4'd8, 64'h0706_0504_0302_0121);
        queue_direct(29'h7DC, 4'd8, 64'h0000_0001_0163_0E10);
        queue_direct(29'h1FFFFFFF, 4'd4, 64'h0000_0000_3332_3122);
        queue_direct(29'h7DC, 4'd5, 64'h0000_0001_0162_1E10);
        queue_direct(29'h7DC, 4'd8, 64'h0000_0000_0000_0023);
        // 64-byte message filling the buffer exactly
        queue_direct(29'h7DC, 4'd8, 64'hA3A2_A101_0162_4010);
        for (int k = 1; k <= 9; k++) begin
            blk = {$urandom, $urandom};
            seq4 = 4'(k);
            blk[7:0] = {isotp_rx_pkg::PCI_CONSECUTIVE, seq4};
            queue_direct(29'h7DC, 4'd8, blk);
        end
        wait_quiet();

        load_settings(29'h1FFFFFFF, 8'hFF, 16'hFFFF, 16'h0000, 16'h1234, 16'hABCD, 4'hF);
        random_traffic(130);
        wait_quiet();

        load_settings(29'h0, 8'h00, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 4'h0);
        random_traffic(35);
        wait_quiet();

        // receiver holds off while frames keep coming
        load_settings(29'($urandom), 8'h62, 16'($urandom), 16'($urandom), 16'h0101,
                      16'($urandom), 4'b1010);
        hold_req = 1'b1;
        random_traffic(130);
        wait_quiet();

        load_settings(29'h7DC, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 4'($urandom_range(1, 15)));
        s_idle_on = 1'b0;
        m_idle_on = 1'b0;
        random_traffic(115);
        wait_quiet();

        $display("%0d frames taken under %0d register settings", frames_taken, settings_used);
        $display("%0d message bytes checked in %0d messages", bytes_seen, msgs_seen);
        if (failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* isotp_receive_reassembler_core.f */
rtl/isotp_rx_pkg.sv
rtl/isotp_rx_ram.sv
rtl/isotp_rx_ctrl.sv
rtl/isotp_rx_dp.sv
rtl/isotp_receive_reassembler_core.sv
dv/tb_top.sv
